@@ hw/rtl/fra_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fra_pkg
// Shared constants and codes for the fraction arithmetic reducer.
// ----------------------------------------------------------------------------
package fra_pkg;

  localparam int DEF_OPERAND_BITS = 16;
  localparam int NUM_OUT_W        = 33;
  localparam int DEN_OUT_W        = 31;
  localparam int STATUS_W         = 2;
  localparam int FUNC_W           = 2;
  localparam int OUT_DATA_W       = 72;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD = 2'd0,
    FN_SUB = 2'd1,
    FN_MUL = 2'd2,
    FN_DIV = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK       = 2'd0,
    STS_ZERO_DEN = 2'd1,
    STS_DIV_ZERO = 2'd2,
    STS_RSVD     = 2'd3
  } status_t;

endpackage
`default_nettype wire

@@ hw/rtl/fraction_arith_reduce.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fraction_arith_reduce
// Exact add, subtract, multiply and divide of two signed fractions, with the
// result reduced to lowest terms and the sign carried by the numerator.
//
//   channel | dir | handshake           | payload
//   in_     | in  | in_tvalid/in_tready | func, num_a, den_a, num_b, den_b
//   out_    | out | out_tvalid/out_tready | num_out, den_out, status
//
// One item is in flight at a time; in_tready is high only when idle.
// A shared subtractor runs a binary gcd and a restoring divider; one
// multiplier is reused for the products. A flagged error, or a zero product
// or sum, ends without the last gcd pass and divisions; otherwise multiply
// and divide run one gcd pass and two divisions, and add and subtract two
// gcd passes and four divisions.
// Reset is synchronous and active low; a stalled result holds in the output
// register until it is taken.
// ----------------------------------------------------------------------------
module fraction_arith_reduce #(
  parameter int OPERAND_BITS = fra_pkg::DEF_OPERAND_BITS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // func, num_a, den_a, num_b, den_b from the lowest bit up, zero padded
  input  wire logic [((fra_pkg::FUNC_W + 4*OPERAND_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  output logic      out_tvalid,
  input  wire logic out_tready,
  // num_out, den_out, status from the lowest bit up, zero padded
  output logic [fra_pkg::OUT_DATA_W-1:0] out_tdata
);
  import fra_pkg::*;

  localparam int OPB = OPERAND_BITS;
  localparam int W   = 2 * OPB;
  localparam int KW  = $clog2(W + 1);
  localparam int CW  = $clog2(W);
  localparam int XW  = (W + 1 > NUM_OUT_W) ? W + 1 : NUM_OUT_W;
  localparam int DW  = (W > DEN_OUT_W) ? W : DEN_OUT_W;
  localparam int PADW = OUT_DATA_W - NUM_OUT_W - DEN_OUT_W - STATUS_W;

  typedef enum logic [13:0] {
    ST_IDLE  = 14'b00000000000001,
    ST_GCD1  = 14'b00000000000010,
    ST_DIVFB = 14'b00000000000100,
    ST_DIVFA = 14'b00000000001000,
    ST_MULA  = 14'b00000000010000,
    ST_MULB  = 14'b00000000100000,
    ST_MULD  = 14'b00000001000000,
    ST_SUM   = 14'b00000010000000,
    ST_MULN2 = 14'b00000100000000,
    ST_MULD2 = 14'b00001000000000,
    ST_GCD2  = 14'b00010000000000,
    ST_DIVN  = 14'b00100000000000,
    ST_DIVD  = 14'b01000000000000,
    ST_DONE  = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [FUNC_W-1:0] func_r, func_nxt;
  logic [OPB-1:0] na_r, na_nxt, da_r, da_nxt, nb_r, nb_nxt, db_r, db_nxt;
  logic [OPB-1:0] fa_r, fa_nxt, fb_r, fb_nxt;
  logic sa_r, sa_nxt, sbe_r, sbe_nxt, neg_r, neg_nxt;
  logic [W-1:0] ga_r, ga_nxt, gb_r, gb_nxt, g_r, g_nxt;
  logic [KW-1:0] gk_r, gk_nxt;
  logic [W-1:0] rem_r, rem_nxt, quo_r, quo_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0] ta_r, ta_nxt, tb_r, tb_nxt, nmag_r, nmag_nxt, dmag_r, dmag_nxt;
  logic [W-1:0] n_r, n_nxt;
  logic [NUM_OUT_W-1:0] onum_r, onum_nxt;
  logic [DEN_OUT_W-1:0] oden_r, oden_nxt;
  status_t ostat_r, ostat_nxt;
  logic ovalid_r, ovalid_nxt;

  // Input field decode
  logic [FUNC_W-1:0] in_func;
  logic [OPB-1:0] raw_na, raw_da, raw_nb, raw_db;
  logic [OPB-1:0] m_na, m_da, m_nb, m_db;
  logic in_sa, in_sb;

  assign in_func = in_tdata[FUNC_W-1:0];
  assign raw_na  = in_tdata[FUNC_W + 0*OPB +: OPB];
  assign raw_da  = in_tdata[FUNC_W + 1*OPB +: OPB];
  assign raw_nb  = in_tdata[FUNC_W + 2*OPB +: OPB];
  assign raw_db  = in_tdata[FUNC_W + 3*OPB +: OPB];
  assign m_na = raw_na[OPB-1] ? (~raw_na + 1'b1) : raw_na;
  assign m_da = raw_da[OPB-1] ? (~raw_da + 1'b1) : raw_da;
  assign m_nb = raw_nb[OPB-1] ? (~raw_nb + 1'b1) : raw_nb;
  assign m_db = raw_db[OPB-1] ? (~raw_db + 1'b1) : raw_db;
  assign in_sa = raw_na[OPB-1] ^ raw_da[OPB-1];
  assign in_sb = raw_nb[OPB-1] ^ raw_db[OPB-1];

  // Shared subtractor, used by the gcd and by the divider
  logic in_gcd;
  logic [W:0] sub_a, sub_b, rem_sh;
  logic [W+1:0] diff;
  logic borrow;
  logic [W-1:0] q_fin;
  logic div_last;

  assign in_gcd = (state_r == ST_GCD1) || (state_r == ST_GCD2);
  assign rem_sh = {rem_r, quo_r[W-1]};
  assign sub_a  = in_gcd ? {1'b0, ga_r} : rem_sh;
  assign sub_b  = in_gcd ? {1'b0, gb_r} : {1'b0, g_r};
  assign diff   = {1'b0, sub_a} - {1'b0, sub_b};
  assign borrow = diff[W+1];
  assign q_fin  = {quo_r[W-2:0], ~borrow};
  assign div_last = (cnt_r == CW'(W - 1));

  // Shared multiplier
  logic [OPB-1:0] mul_x, mul_y;
  logic [W-1:0] prod;

  always_comb begin
    mul_x = na_r;
    mul_y = fa_r;
    unique case (state_r)
      ST_MULA:  begin mul_x = na_r; mul_y = fa_r; end
      ST_MULB:  begin mul_x = nb_r; mul_y = fb_r; end
      ST_MULD:  begin mul_x = fa_r; mul_y = da_r; end
      ST_MULN2: begin mul_x = na_r; mul_y = (func_r == FN_MUL) ? nb_r : db_r; end
      ST_MULD2: begin mul_x = da_r; mul_y = (func_r == FN_MUL) ? db_r : nb_r; end
      default:  begin mul_x = na_r; mul_y = fa_r; end
    endcase
  end
  assign prod = W'(mul_x) * W'(mul_y);

  // Signed combine of the scaled numerators
  logic [W-1:0] sum_mag;
  logic sum_neg;

  always_comb begin
    if (sa_r == sbe_r) begin
      sum_mag = ta_r + tb_r;
      sum_neg = sa_r;
    end else if (ta_r >= tb_r) begin
      sum_mag = ta_r - tb_r;
      sum_neg = sa_r;
    end else begin
      sum_mag = tb_r - ta_r;
      sum_neg = sbe_r;
    end
  end

  // Final sign and truncation to the output widths
  logic [XW-1:0] n_ext, n_sgn;
  logic [DW-1:0] d_ext;

  assign n_ext = XW'(n_r);
  assign n_sgn = neg_r ? (~n_ext + 1'b1) : n_ext;
  assign d_ext = DW'(q_fin);

  always_comb begin
    state_nxt = state_r;
    func_nxt = func_r;
    na_nxt = na_r; da_nxt = da_r; nb_nxt = nb_r; db_nxt = db_r;
    fa_nxt = fa_r; fb_nxt = fb_r;
    sa_nxt = sa_r; sbe_nxt = sbe_r; neg_nxt = neg_r;
    ga_nxt = ga_r; gb_nxt = gb_r; g_nxt = g_r; gk_nxt = gk_r;
    rem_nxt = rem_r; quo_nxt = quo_r; cnt_nxt = cnt_r;
    ta_nxt = ta_r; tb_nxt = tb_r; nmag_nxt = nmag_r; dmag_nxt = dmag_r;
    n_nxt = n_r;
    onum_nxt = onum_r; oden_nxt = oden_r; ostat_nxt = ostat_r;
    ovalid_nxt = ovalid_r;

    // Common divider step; the state decides where the quotient goes.
    if (!in_gcd) begin
      rem_nxt = borrow ? rem_sh[W-1:0] : diff[W-1:0];
      quo_nxt = q_fin;
      cnt_nxt = cnt_r + 1'b1;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          func_nxt = in_func;
          na_nxt = m_na; da_nxt = m_da; nb_nxt = m_nb; db_nxt = m_db;
          sa_nxt = in_sa;
          sbe_nxt = (in_func == FN_SUB) ? ~in_sb : in_sb;
          neg_nxt = in_sa ^ in_sb;
          ga_nxt = W'(m_da);
          gb_nxt = W'(m_db);
          gk_nxt = '0;
          onum_nxt = '0;
          oden_nxt = DEN_OUT_W'(1);
          if (m_da == '0 || m_db == '0) begin
            ostat_nxt = STS_ZERO_DEN;
            ovalid_nxt = 1'b1;
            state_nxt = ST_DONE;
          end else if (in_func == FN_DIV && m_nb == '0) begin
            ostat_nxt = STS_DIV_ZERO;
            ovalid_nxt = 1'b1;
            state_nxt = ST_DONE;
          end else if (in_func == FN_ADD || in_func == FN_SUB) begin
            state_nxt = ST_GCD1;
          end else begin
            state_nxt = ST_MULN2;
          end
        end
      end
      ST_GCD1, ST_GCD2: begin
        // Binary gcd: strip common twos, then subtract the smaller.
        if (ga_r == gb_r) begin
          g_nxt = ga_r << gk_r;
          rem_nxt = '0;
          cnt_nxt = '0;
          if (state_r == ST_GCD1) begin
            quo_nxt = W'(da_r);
            state_nxt = ST_DIVFB;
          end else begin
            quo_nxt = nmag_r;
            state_nxt = ST_DIVN;
          end
        end else if (!ga_r[0] && !gb_r[0]) begin
          ga_nxt = ga_r >> 1;
          gb_nxt = gb_r >> 1;
          gk_nxt = gk_r + 1'b1;
        end else if (!ga_r[0]) begin
          ga_nxt = ga_r >> 1;
        end else if (!gb_r[0]) begin
          gb_nxt = gb_r >> 1;
        end else if (borrow) begin
          ga_nxt = gb_r;
          gb_nxt = ga_r;
        end else begin
          ga_nxt = diff[W-1:0];
        end
      end
      ST_DIVFB: begin
        if (div_last) begin
          fb_nxt = q_fin[OPB-1:0];
          rem_nxt = '0;
          quo_nxt = W'(db_r);
          cnt_nxt = '0;
          state_nxt = ST_DIVFA;
        end
      end
      ST_DIVFA: begin
        if (div_last) begin
          fa_nxt = q_fin[OPB-1:0];
          state_nxt = ST_MULA;
        end
      end
      ST_MULA: begin
        ta_nxt = prod;
        state_nxt = ST_MULB;
      end
      ST_MULB: begin
        tb_nxt = prod;
        state_nxt = ST_MULD;
      end
      ST_MULD: begin
        dmag_nxt = prod;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        nmag_nxt = sum_mag;
        neg_nxt = sum_neg;
        ga_nxt = sum_mag;
        gb_nxt = dmag_r;
        gk_nxt = '0;
        if (sum_mag == '0) begin
          onum_nxt = '0;
          oden_nxt = DEN_OUT_W'(1);
          ostat_nxt = STS_OK;
          ovalid_nxt = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_GCD2;
        end
      end
      ST_MULN2: begin
        nmag_nxt = prod;
        state_nxt = ST_MULD2;
      end
      ST_MULD2: begin
        dmag_nxt = prod;
        ga_nxt = nmag_r;
        gb_nxt = prod;
        gk_nxt = '0;
        if (nmag_r == '0) begin
          onum_nxt = '0;
          oden_nxt = DEN_OUT_W'(1);
          ostat_nxt = STS_OK;
          ovalid_nxt = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_GCD2;
        end
      end
      ST_DIVN: begin
        if (div_last) begin
          n_nxt = q_fin;
          rem_nxt = '0;
          quo_nxt = dmag_r;
          cnt_nxt = '0;
          state_nxt = ST_DIVD;
        end
      end
      ST_DIVD: begin
        if (div_last) begin
          onum_nxt = n_sgn[NUM_OUT_W-1:0];
          oden_nxt = d_ext[DEN_OUT_W-1:0];
          ostat_nxt = STS_OK;
          ovalid_nxt = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_tready) begin
          ovalid_nxt = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        ovalid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r <= func_nxt;
    na_r <= na_nxt; da_r <= da_nxt; nb_r <= nb_nxt; db_r <= db_nxt;
    fa_r <= fa_nxt; fb_r <= fb_nxt;
    sa_r <= sa_nxt; sbe_r <= sbe_nxt; neg_r <= neg_nxt;
    ga_r <= ga_nxt; gb_r <= gb_nxt; g_r <= g_nxt; gk_r <= gk_nxt;
    rem_r <= rem_nxt; quo_r <= quo_nxt; cnt_r <= cnt_nxt;
    ta_r <= ta_nxt; tb_r <= tb_nxt; nmag_r <= nmag_nxt; dmag_r <= dmag_nxt;
    n_r <= n_nxt;
    onum_r <= onum_nxt; oden_r <= oden_nxt; ostat_r <= ostat_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = {PADW'(0), ostat_r, oden_r, onum_r};

`ifndef SYNTH
  a_busy_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while a result is pending");
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (oden_r != '0))
    else $error("zero denominator presented");
  a_err_zero_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && ostat_r != STS_OK) |-> (onum_r == '0 && oden_r == DEN_OUT_W'(1)))
    else $error("error result is not 0/1");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("ready stayed high after a transfer");
`endif

endmodule
`default_nettype wire
